@@ rtl/dprim_pkg.sv @@
// Shared types and constants for the dense Prim spanning tree engine.
`default_nettype none
package dprim_pkg;

	// Item operation codes
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_COMPUTE = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;
	localparam logic [1:0] MODE_NONE    = 2'd3;

	// Configuration register indexes
	localparam logic CFG_VERTEX_COUNT = 1'b0;
	localparam logic CFG_START_VERTEX = 1'b1;

	localparam int CFG_WIDTH   = 7;
	localparam int TOTAL_WIDTH = 22;
	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  vertex_a;
		logic [5:0]  vertex_b;
		logic [15:0] weight_in;
	} in_item_t;

	typedef struct packed {
		logic [5:0]             tree_vertex;
		logic [5:0]             parent_vertex;
		logic [15:0]            attach_weight;
		logic                   unreachable;
		logic [TOTAL_WIDTH-1:0] total_weight;
		logic                   last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD2,
		ST_SCAN,
		ST_FIN,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

@@ rtl/dense_prim_mst_engine_core.sv @@
// Top level of the dense Prim minimum spanning tree engine.
// Load item: writes both directions of the edge. Clear item: zeroes every
// adjacency entry through the single RAM write port.
// Compute item: n-1 passes, each a scan with one adjacency read per cycle, then
// a wait until the result is taken. After reset the same clearing pass runs and no
// item is accepted until it ends; configuration writes are taken at any time.
`default_nettype none
module dense_prim_mst_engine_core #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire dprim_pkg::in_item_t             in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output dprim_pkg::out_item_t                 out_data,
	input  wire logic                            cfg_write,
	input  wire logic                            cfg_index,
	input  wire logic [dprim_pkg::CFG_WIDTH-1:0] cfg_data
);

	localparam int VB   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW   = VB + 1;
	localparam int AW   = 2 * VB;
	localparam int DW   = WEIGHT_BITS + 1;
	localparam int VW   = 1 + DW + VB;
	localparam int SW   = ((DW > dprim_pkg::TOTAL_WIDTH) ? DW : dprim_pkg::TOTAL_WIDTH) + 1;
	localparam logic [DW-1:0] DIST_INF = DW'(1) << WEIGHT_BITS;

	dprim_pkg::state_t state_q, state_d;

	logic [dprim_pkg::CFG_WIDTH-1:0] vcount_q;
	logic [5:0]                      start_q;

	logic [AW-1:0]   clr_cnt_q;
	logic [VB-1:0]   load_a_q, load_b_q;
	logic [WEIGHT_BITS-1:0] load_w_q;
	logic [NW-1:0]   rd_idx_q;
	logic            v_s1;
	logic [VB-1:0]   idx_s1;
	logic [VB-1:0]   pick_q;
	logic            first_q;
	logic            found_q;
	logic [DW-1:0]   bd_q;
	logic [VB-1:0]   bi_q, bp_q;
	logic [NW-1:0]   step_q;
	logic [dprim_pkg::TOTAL_WIDTH-1:0] total_q;
	dprim_pkg::out_item_t out_q;

	// Effective vertex count and start vertex
	logic [11:0]   vc_ext, st_ext, max_ext;
	logic [NW-1:0] n_eff;
	logic [VB-1:0] s_eff;
	always_comb begin
		vc_ext  = 12'(vcount_q);
		st_ext  = 12'(start_q);
		max_ext = 12'(MAX_VERTICES);
		if (vc_ext == 12'd0) begin
			n_eff = NW'(1);
		end else if (vc_ext > max_ext) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = NW'(vcount_q);
		end
		s_eff = (st_ext < 12'(n_eff)) ? VB'(start_q) : '0;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= dprim_pkg::CFG_WIDTH'(64);
			start_q  <= '0;
		end else if (cfg_write) begin
			if (cfg_index == dprim_pkg::CFG_VERTEX_COUNT) begin
				vcount_q <= cfg_data;
			end else begin
				start_q <= cfg_data[5:0];
			end
		end
	end

	// Memories
	logic                   adj_we;
	logic [AW-1:0]          adj_waddr, adj_raddr;
	logic [WEIGHT_BITS-1:0] adj_wdata, adj_rdata;
	logic                   vtx_we;
	logic [VB-1:0]          vtx_waddr, vtx_raddr;
	logic [VW-1:0]          vtx_wdata, vtx_rdata;

	dprim_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << AW)) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	dprim_ram #(.WIDTH(VW), .DEPTH(1 << VB)) u_vtx_ram (
		.clk   (clk),
		.we    (vtx_we),
		.waddr (vtx_waddr),
		.wdata (vtx_wdata),
		.raddr (vtx_raddr),
		.rdata (vtx_rdata)
	);

	// Input decode
	logic                   in_xfer;
	logic                   load_ok;
	logic [VB-1:0]          in_a, in_b;
	logic [WEIGHT_BITS-1:0] in_w;
	assign in_xfer = in_valid && in_ready;
	assign load_ok = (12'(in_data.vertex_a) < max_ext) && (12'(in_data.vertex_b) < max_ext);
	assign in_a    = VB'(in_data.vertex_a);
	assign in_b    = VB'(in_data.vertex_b);
	assign in_w    = WEIGHT_BITS'(in_data.weight_in);

	// Scan stage: relax from pick and search the nearest non-member
	logic              rd_mem;
	logic [DW-1:0]     rd_dist;
	logic [VB-1:0]     rd_par;
	logic              cur_mem, upd, cand;
	logic [DW-1:0]     old_d, new_d;
	logic [VB-1:0]     old_p, new_p;
	always_comb begin
		rd_mem  = vtx_rdata[VW-1];
		rd_dist = vtx_rdata[VW-2 -: DW];
		rd_par  = vtx_rdata[VB-1:0];
		old_d   = first_q ? DIST_INF : rd_dist;
		old_p   = first_q ? '0 : rd_par;
		cur_mem = (first_q ? 1'b0 : rd_mem) || (idx_s1 == pick_q);
		upd     = (adj_rdata != '0) && (old_d > DW'(adj_rdata));
		new_d   = upd ? DW'(adj_rdata) : old_d;
		new_p   = upd ? pick_q : old_p;
		cand    = !cur_mem && (!found_q || (bd_q > new_d));
	end

	// Memory port control
	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = {load_b_q, load_a_q};
		adj_wdata = load_w_q;
		case (state_q)
			dprim_pkg::ST_CLEAR: begin
				adj_we    = 1'b1;
				adj_waddr = clr_cnt_q;
				adj_wdata = '0;
			end
			dprim_pkg::ST_IDLE: begin
				adj_we    = in_xfer && (in_data.mode == dprim_pkg::MODE_LOAD) && load_ok;
				adj_waddr = {in_a, in_b};
				adj_wdata = in_w;
			end
			dprim_pkg::ST_LOAD2: begin
				adj_we = 1'b1;
			end
			default: begin
				adj_we = 1'b0;
			end
		endcase
		adj_raddr = {pick_q, rd_idx_q[VB-1:0]};
		vtx_raddr = rd_idx_q[VB-1:0];
		vtx_we    = v_s1;
		vtx_waddr = idx_s1;
		vtx_wdata = {cur_mem, new_d, new_p};
	end

	// Result of a finished pass
	logic              unreach;
	logic [SW-1:0]     sum;
	logic [dprim_pkg::TOTAL_WIDTH-1:0] total_next;
	logic [NW-1:0]     step_next;
	always_comb begin
		unreach    = bd_q[WEIGHT_BITS];
		sum        = SW'(total_q) + SW'(bd_q);
		if (unreach) begin
			total_next = total_q;
		end else if (sum > SW'(dprim_pkg::TOTAL_MAX)) begin
			total_next = dprim_pkg::TOTAL_MAX;
		end else begin
			total_next = dprim_pkg::TOTAL_WIDTH'(sum);
		end
		step_next = step_q + NW'(1);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dprim_pkg::ST_CLEAR: begin
				if (clr_cnt_q == '1) begin
					state_d = dprim_pkg::ST_IDLE;
				end
			end
			dprim_pkg::ST_IDLE: begin
				if (in_xfer) begin
					case (in_data.mode)
						dprim_pkg::MODE_LOAD: state_d = load_ok ? dprim_pkg::ST_LOAD2
							: dprim_pkg::ST_IDLE;
						dprim_pkg::MODE_COMPUTE: state_d = dprim_pkg::ST_SCAN;
						dprim_pkg::MODE_CLEAR: state_d = dprim_pkg::ST_CLEAR;
						default: state_d = dprim_pkg::ST_IDLE;
					endcase
				end
			end
			dprim_pkg::ST_LOAD2: state_d = dprim_pkg::ST_IDLE;
			dprim_pkg::ST_SCAN: begin
				if (v_s1 && (NW'(idx_s1) == n_eff - NW'(1))) begin
					state_d = dprim_pkg::ST_FIN;
				end
			end
			dprim_pkg::ST_FIN: begin
				state_d = found_q ? dprim_pkg::ST_EMIT : dprim_pkg::ST_IDLE;
			end
			dprim_pkg::ST_EMIT: begin
				if (out_ready) begin
					state_d = (step_q == n_eff - NW'(1)) ? dprim_pkg::ST_IDLE
						: dprim_pkg::ST_SCAN;
				end
			end
			default: state_d = dprim_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dprim_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			rd_idx_q  <= '0;
			v_s1      <= 1'b0;
			first_q   <= 1'b0;
			found_q   <= 1'b0;
			step_q    <= '0;
			total_q   <= '0;
		end else begin
			v_s1 <= 1'b0;
			case (state_q)
				dprim_pkg::ST_CLEAR: clr_cnt_q <= clr_cnt_q + AW'(1);
				dprim_pkg::ST_IDLE: begin
					clr_cnt_q <= '0;
					rd_idx_q  <= '0;
					first_q   <= 1'b1;
					found_q   <= 1'b0;
					step_q    <= '0;
					total_q   <= '0;
				end
				dprim_pkg::ST_SCAN: begin
					if (rd_idx_q < n_eff) begin
						rd_idx_q <= rd_idx_q + NW'(1);
						v_s1     <= 1'b1;
					end
					if (v_s1 && cand) begin
						found_q <= 1'b1;
					end
				end
				dprim_pkg::ST_FIN: begin
					if (found_q) begin
						step_q  <= step_next;
						total_q <= total_next;
					end
				end
				dprim_pkg::ST_EMIT: begin
					rd_idx_q <= '0;
					first_q  <= 1'b0;
					found_q  <= 1'b0;
				end
				default: begin
					clr_cnt_q <= clr_cnt_q;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[VB-1:0];
		if (state_q == dprim_pkg::ST_IDLE) begin
			load_a_q <= in_a;
			load_b_q <= in_b;
			load_w_q <= in_w;
			pick_q   <= s_eff;
		end
		if (state_q == dprim_pkg::ST_EMIT) begin
			pick_q <= bi_q;
		end
		if (state_q == dprim_pkg::ST_SCAN && v_s1 && cand) begin
			bd_q <= new_d;
			bi_q <= idx_s1;
			bp_q <= new_p;
		end
		if (state_q == dprim_pkg::ST_FIN) begin
			out_q.tree_vertex   <= 6'(bi_q);
			out_q.parent_vertex <= unreach ? 6'd0 : 6'(bp_q);
			out_q.attach_weight <= unreach ? 16'd0 : 16'(bd_q[WEIGHT_BITS-1:0]);
			out_q.unreachable   <= unreach;
			out_q.total_weight  <= total_next;
			out_q.last          <= (step_next == n_eff - NW'(1));
		end
	end

	assign in_ready  = (state_q == dprim_pkg::ST_IDLE);
	assign out_valid = (state_q == dprim_pkg::ST_EMIT);
	assign out_data  = out_q;

	// Checks
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.unreachable |->
			out_data.parent_vertex == 6'd0 && out_data.attach_weight == 16'd0)
		else $error("unreachable result carries parent or weight");

	a_fin_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dprim_pkg::ST_FIN |-> found_q || n_eff == NW'(1))
		else $error("pass ended with no candidate vertex");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dprim_pkg::ST_SCAN |-> rd_idx_q <= n_eff)
		else $error("scan index ran past vertex count");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dprim_pkg::ST_FIN && step_q != '0 |=> total_q >= $past(total_q))
		else $error("running total decreased");

endmodule
`default_nettype wire

@@ rtl/dprim_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module dprim_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the dense Prim spanning tree engine: directed and random items, self-checking.
`timescale 1ns / 1ps
module testbench;

	localparam int NV        = 64;
	localparam int LIMIT     = 3000000;
	localparam int DRAIN_CYC = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	dprim_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	dprim_pkg::out_item_t out_data;
	logic cfg_write = 1'b0;
	logic cfg_index = 1'b0;
	logic [dprim_pkg::CFG_WIDTH-1:0] cfg_data = '0;

	always #2 clk = ~clk;

	dense_prim_mst_engine_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] edge_w [NV*NV];
	logic [16:0] near_d [NV];
	logic [5:0] par [NV];
	bit in_tree [NV];
	logic [6:0] cnt_reg = 7'd64;
	logic [5:0] start_reg = 6'd0;
	dprim_pkg::out_item_t tree_q [$];

	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver ready pattern, with optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		dprim_pkg::out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (tree_q.size() == 0) begin
				$error("unexpected transfer %h", out_data);
				errors++;
			end else begin
				e = tree_q.pop_front();
				if (out_data.tree_vertex !== e.tree_vertex) begin
					$error("tree_vertex exp %0d got %0d", e.tree_vertex, out_data.tree_vertex);
					errors++;
				end
				if (out_data.parent_vertex !== e.parent_vertex) begin
					$error("parent_vertex exp %0d got %0d", e.parent_vertex,
						out_data.parent_vertex);
					errors++;
				end
				if (out_data.attach_weight !== e.attach_weight) begin
					$error("attach_weight exp %0d got %0d", e.attach_weight,
						out_data.attach_weight);
					errors++;
				end
				if (out_data.unreachable !== e.unreachable) begin
					$error("unreachable exp %0d got %0d", e.unreachable, out_data.unreachable);
					errors++;
				end
				if (out_data.total_weight !== e.total_weight) begin
					$error("total_weight exp %0d got %0d", e.total_weight,
						out_data.total_weight);
					errors++;
				end
				if (out_data.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, out_data.last);
					errors++;
				end
			end
		end
	end

	task automatic relax(input int added, input int n);
		for (int i = 0; i < n; i++)
			if (edge_w[added*NV+i] != 0 && near_d[i] > {1'b0, edge_w[added*NV+i]}) begin
				near_d[i] = {1'b0, edge_w[added*NV+i]};
				par[i] = added[5:0];
			end
	endtask

	// model update and expected tree for one item
	task automatic predict_tree(input dprim_pkg::in_item_t it);
		int n, s, pick;
		bit found;
		logic [22:0] total;
		dprim_pkg::out_item_t r;
		if (it.mode == dprim_pkg::MODE_LOAD) begin
			edge_w[it.vertex_a*NV+it.vertex_b] = it.weight_in;
			edge_w[it.vertex_b*NV+it.vertex_a] = it.weight_in;
		end else if (it.mode == dprim_pkg::MODE_CLEAR) begin
			foreach (edge_w[i]) edge_w[i] = '0;
		end else if (it.mode == dprim_pkg::MODE_COMPUTE) begin
			n = cnt_reg;
			if (n < 1) n = 1;
			if (n > NV) n = NV;
			s = start_reg;
			if (s >= n) s = 0;
			total = '0;
			for (int i = 0; i < NV; i++) begin
				near_d[i] = 17'h10000;
				par[i] = '0;
				in_tree[i] = 1'b0;
			end
			near_d[s] = '0;
			in_tree[s] = 1'b1;
			relax(s, n);
			for (int step = 1; step < n; step++) begin
				pick = 0;
				found = 1'b0;
				for (int i = 0; i < n; i++)
					if (!in_tree[i] && (!found || near_d[pick] > near_d[i])) begin
						pick = i;
						found = 1'b1;
					end
				r.tree_vertex = pick[5:0];
				r.unreachable = near_d[pick][16];
				if (!r.unreachable) begin
					total = total + near_d[pick];
					if (total > dprim_pkg::TOTAL_MAX) total = dprim_pkg::TOTAL_MAX;
				end
				r.parent_vertex = r.unreachable ? 6'd0 : par[pick];
				r.attach_weight = r.unreachable ? 16'd0 : near_d[pick][15:0];
				r.total_weight = total[21:0];
				r.last = (step + 1 == n);
				tree_q.push_back(r);
				in_tree[pick] = 1'b1;
				relax(pick, n);
			end
		end
	endtask

	// one item transfer, with random idle before it; valid drops only while idle
	task automatic send_item(input dprim_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		predict_tree(it);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_edge(input int a, input int b, input int w);
		dprim_pkg::in_item_t it;
		it.mode = dprim_pkg::MODE_LOAD;
		it.vertex_a = a[5:0];
		it.vertex_b = b[5:0];
		it.weight_in = w[15:0];
		send_item(it);
	endtask

	task automatic send_op(input logic [1:0] m);
		dprim_pkg::in_item_t it;
		{it.vertex_a, it.vertex_b, it.weight_in} = 28'($urandom);
		it.mode = m;
		send_item(it);
	endtask

	// wait for every expected result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (tree_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic write_cfg(input logic idx, input int val);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[dprim_pkg::CFG_WIDTH-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == dprim_pkg::CFG_VERTEX_COUNT) cnt_reg = val[6:0];
		else start_reg = val[5:0];
	endtask

	// directed: extremes, self loop, unreachable, ties, wide counts, unused mode
	task automatic test_directed();
		write_cfg(dprim_pkg::CFG_VERTEX_COUNT, 5);
		send_edge(0, 1, 16'hFFFF);
		send_edge(1, 2, 3);
		send_edge(2, 2, 1);
		send_edge(0, 2, 3);
		send_edge(63, 63, 16'hAAAA);
		send_op(dprim_pkg::MODE_COMPUTE);
		write_cfg(dprim_pkg::CFG_START_VERTEX, 2);
		send_op(dprim_pkg::MODE_COMPUTE);
		write_cfg(dprim_pkg::CFG_START_VERTEX, 63);
		send_op(dprim_pkg::MODE_COMPUTE);
		send_op(dprim_pkg::MODE_NONE);
		write_cfg(dprim_pkg::CFG_VERTEX_COUNT, 0);
		send_op(dprim_pkg::MODE_COMPUTE);
		write_cfg(dprim_pkg::CFG_VERTEX_COUNT, 127);
		write_cfg(dprim_pkg::CFG_START_VERTEX, 63);
		for (int i = 0; i < 63; i++) send_edge(i, i + 1, 16'hFFFF);
		send_op(dprim_pkg::MODE_COMPUTE);
		send_edge(0, 1, 0);
		send_op(dprim_pkg::MODE_COMPUTE);
		send_op(dprim_pkg::MODE_CLEAR);
		write_cfg(dprim_pkg::CFG_VERTEX_COUNT, 2);
		write_cfg(dprim_pkg::CFG_START_VERTEX, 1);
		send_op(dprim_pkg::MODE_COMPUTE);
	endtask

	// random: small graphs loaded then computed, with some noise
	task automatic test_random(input int items);
		int n, k, r;
		k = 0;
		while (k < items) begin
			r = $urandom_range(9);
			n = (r == 0) ? $urandom_range(64, 127) : $urandom_range(1, 10);
			write_cfg(dprim_pkg::CFG_VERTEX_COUNT, n);
			write_cfg(dprim_pkg::CFG_START_VERTEX, $urandom_range(r == 1 ? 63 : 10));
			if ($urandom_range(3) == 0) begin
				send_op(dprim_pkg::MODE_CLEAR);
				k++;
			end
			for (int j = $urandom_range(3, 12); j > 0; j--) begin
				if ($urandom_range(9) == 0) send_op(dprim_pkg::MODE_NONE);
				else if ($urandom_range(4) == 0)
					send_edge($urandom_range(63), $urandom_range(63), $urandom);
				else
					send_edge($urandom_range(9), $urandom_range(9),
						$urandom_range(3) == 0 ? $urandom_range(3) : $urandom);
				k++;
			end
			send_op(dprim_pkg::MODE_COMPUTE);
			k++;
			if ($urandom_range(2) == 0) begin
				send_op(dprim_pkg::MODE_COMPUTE);
				k++;
			end
		end
	endtask

	// long receiver hold-off while computes keep coming
	task automatic test_backpressure();
		write_cfg(dprim_pkg::CFG_VERTEX_COUNT, 8);
		write_cfg(dprim_pkg::CFG_START_VERTEX, 0);
		for (int i = 0; i < 7; i++) send_edge(i, i + 1, $urandom);
		hold_cycles = 3000;
		repeat (6) send_op(dprim_pkg::MODE_COMPUTE);
		drain();
	endtask

	initial begin
		foreach (edge_w[i]) edge_w[i] = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		send_idle_pct = 0; recv_stall_pct = 0;
		test_random(10);
		send_idle_pct = 62; recv_stall_pct = 0;
		test_random(10);
		send_idle_pct = 0; recv_stall_pct = 62;
		test_random(10);
		send_idle_pct = 10; recv_stall_pct = 10;
		test_random(10);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_backpressure();
		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/dprim_pkg.sv
rtl/dprim_ram.sv
rtl/dense_prim_mst_engine_core.sv
tb/testbench.sv
